// File: hdl/pts_pkg.sv
// Package with the types, codes and constants of the priority thread scheduler.
package pts_pkg;

  localparam int unsigned ThreadSlots    = 8;
  localparam int unsigned PeriodicSlots  = 4;
  localparam int unsigned PeriodicMax    = 4;
  localparam int unsigned NumCfgRegs     = 5;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 16;
  localparam int unsigned FifoDepth      = 2;
  localparam logic [15:0] PeriodReset    = 16'd1000;

  localparam logic [2:0] ActTick  = 3'd0;
  localparam logic [2:0] ActAdd   = 3'd1;
  localparam logic [2:0] ActKill  = 3'd2;
  localparam logic [2:0] ActSleep = 3'd3;
  localparam logic [2:0] ActBlock = 3'd4;

  localparam logic [CfgIdxW-1:0] RegPeriodicCount = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPeriodA       = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPeriodD       = 3'd4;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusLimit   = 2'd1;
  localparam logic [1:0] StatusLast    = 2'd2;
  localparam logic [1:0] StatusNoMatch = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  priority_req;
    logic [31:0] thread_id;
    logic [31:0] duration;
    logic [2:0]  slot;
    logic        block_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  running_slot;
    logic [31:0] running_id;
    logic [3:0]  periodic_fire;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

// File: hdl/priority_thread_scheduler_unit.sv
// Top level of the priority thread scheduler: config registers, queues and engine.
// A block goes straight to the result; an add searches for a free slot; a sleep rescans;
// a kill searches for the id and rescans if it ran; a tick checks handlers, wakes, rescans.
// Handlers are checked by a bit-serial remainder unit, one bit per cycle per handler.
// One item is worked at a time: a new item is taken only once the last result is queued.
// Reset is asynchronous and active low; it empties the thread table and the queues.
module priority_thread_scheduler_unit #(
  parameter int unsigned ThreadSlots   = pts_pkg::ThreadSlots,
  parameter int unsigned PeriodicSlots = pts_pkg::PeriodicSlots
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  pts_pkg::in_item_t    in_item_i,
  input  logic                 pop,
  output logic                 empty,
  output pts_pkg::out_item_t   out_item_o,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  pts_pkg::cfg_item_t   cfg_item_i
);

  logic [2:0]  pcount_q;
  logic [15:0] periods_q [pts_pkg::PeriodicMax];

  pts_pkg::in_item_t  cmd;
  pts_pkg::out_item_t res;
  logic cmd_empty, cmd_take, res_valid, res_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcount_q <= '0;
      for (int i = 0; i < int'(pts_pkg::PeriodicMax); i++) begin
        periods_q[i] <= pts_pkg::PeriodReset;
      end
    end else if (cfg_valid) begin
      if (cfg_item_i.index == pts_pkg::RegPeriodicCount) begin
        pcount_q <= cfg_item_i.data[2:0];
      end else if (cfg_item_i.index >= pts_pkg::RegPeriodA &&
                   cfg_item_i.index <= pts_pkg::RegPeriodD) begin
        periods_q[2'(cfg_item_i.index - pts_pkg::RegPeriodA)] <= cfg_item_i.data;
      end
    end
  end

  pts_fifo #(.Width($bits(pts_pkg::in_item_t)), .Depth(pts_pkg::FifoDepth)) u_in_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(in_item_i), .full_o(full),
    .pop_i(cmd_take), .data_o(cmd), .empty_o(cmd_empty)
  );

  pts_engine #(.ThreadSlots(ThreadSlots), .PeriodicSlots(PeriodicSlots)) u_engine (
    .clk_i, .rst_ni,
    .cmd_valid_i(!cmd_empty), .cmd_i(cmd), .cmd_take_o(cmd_take),
    .periodic_count_i(pcount_q), .periods_i(periods_q),
    .res_valid_o(res_valid), .res_o(res), .res_full_i(res_full)
  );

  pts_fifo #(.Width($bits(pts_pkg::out_item_t)), .Depth(pts_pkg::FifoDepth)) u_out_fifo (
    .clk_i, .rst_ni,
    .push_i(res_valid), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(out_item_o), .empty_o(empty)
  );

endmodule

// File: hdl/pts_fifo.sv
// Small first-in first-out queue that decouples the front part from the back part.
module pts_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("queue count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !push_i) |=> empty_o)
    else $error("queue became non-empty without a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o)
    else $error("queue left full without a pop");

endmodule

// File: hdl/pts_engine.sv
// Back part: thread table, periodic handlers and the sequential slot selection.
module pts_engine #(
  parameter int unsigned ThreadSlots   = pts_pkg::ThreadSlots,
  parameter int unsigned PeriodicSlots = pts_pkg::PeriodicSlots
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  pts_pkg::in_item_t   cmd_i,
  output logic                cmd_take_o,
  input  logic [2:0]          periodic_count_i,
  input  logic [15:0]         periods_i [pts_pkg::PeriodicMax],
  output logic                res_valid_o,
  output pts_pkg::out_item_t  res_o,
  input  logic                res_full_i
);

  localparam int unsigned SlotW = (ThreadSlots > 1) ? $clog2(ThreadSlots) : 1;
  localparam int unsigned CntW  = $clog2(ThreadSlots + 1);
  localparam int unsigned NumPer = (PeriodicSlots < pts_pkg::PeriodicMax) ?
                                   PeriodicSlots : pts_pkg::PeriodicMax;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StTick = 4'd1;
  localparam logic [3:0] StMod  = 4'd2;
  localparam logic [3:0] StWake = 4'd3;
  localparam logic [3:0] StAdd  = 4'd4;
  localparam logic [3:0] StKill = 4'd5;
  localparam logic [3:0] StScan = 4'd6;
  localparam logic [3:0] StOut  = 4'd7;

  logic [3:0]  state_q, state_d;
  logic [31:0] time_q;
  logic [ThreadSlots-1:0] alive_q, asleep_q, blocked_q;
  logic [7:0]  prio_q  [ThreadSlots];
  logic [31:0] wake_q  [ThreadSlots];
  logic [31:0] ident_q [ThreadSlots];
  logic [15:0] idc_q;
  logic [CntW-1:0] count_q;
  logic [SlotW-1:0] cur_q;

  pts_pkg::in_item_t cmd_q;
  logic [1:0]  status_q;
  logic [3:0]  fire_q;
  logic [SlotW:0] k_q;
  logic [SlotW-1:0] idx_q;
  logic [8:0]  best_q;
  logic [SlotW-1:0] chosen_q;
  logic [2:0]  per_q;
  logic [31:0] rem_q;
  logic [5:0]  bit_q;
  logic [2:0]  n_lim;

  logic [SlotW-1:0] scan_s;
  logic [32:0] rem_sh;
  logic [31:0] wake_diff;

  assign cmd_take_o  = (state_q == StIdle) && cmd_valid_i;
  assign res_valid_o = (state_q == StOut) && !res_full_i;
  assign res_o.status        = status_q;
  assign res_o.running_slot  = 3'(cur_q);
  assign res_o.running_id    = alive_q[cur_q] ? ident_q[cur_q] : 32'd0;
  assign res_o.periodic_fire = fire_q;

  assign n_lim = (periodic_count_i > 3'(NumPer)) ? 3'(NumPer) : periodic_count_i;
  assign scan_s = (ThreadSlots == (1 << SlotW)) ? cur_q + SlotW'(k_q) :
    SlotW'(({1'b0, cur_q} + k_q) >= (SlotW+1)'(ThreadSlots) ?
           ({1'b0, cur_q} + k_q) - (SlotW+1)'(ThreadSlots) : {1'b0, cur_q} + k_q);
  assign rem_sh = {rem_q, time_q[5'(31 - bit_q[4:0])]};
  assign wake_diff = time_q - wake_q[idx_q];

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          case (cmd_i.action)
            pts_pkg::ActTick:  state_d = StTick;
            pts_pkg::ActAdd:   state_d = StAdd;
            pts_pkg::ActKill:  state_d = StKill;
            pts_pkg::ActSleep: state_d = StScan;
            default:           state_d = StOut;
          endcase
        end
      end
      StTick: state_d = StMod;
      StMod: begin
        if (per_q >= n_lim) begin
          state_d = StWake;
        end
      end
      StWake: begin
        if (idx_q == SlotW'(ThreadSlots - 1)) begin
          state_d = StScan;
        end
      end
      StAdd:  if (idx_q == SlotW'(ThreadSlots - 1) || !alive_q[idx_q]) state_d = StOut;
      StKill: begin
        if (count_q == CntW'(1)) begin
          state_d = StOut;
        end else if (alive_q[idx_q] && ident_q[idx_q] == cmd_q.thread_id) begin
          state_d = (idx_q == cur_q) ? StScan : StOut;
        end else if (idx_q == SlotW'(ThreadSlots - 1)) begin
          state_d = StOut;
        end
      end
      StScan: if (k_q == (SlotW+1)'(ThreadSlots)) state_d = StOut;
      StOut:  if (!res_full_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      time_q    <= '0;
      alive_q   <= '0;
      asleep_q  <= '0;
      blocked_q <= '0;
      idc_q     <= '0;
      count_q   <= '0;
      cur_q     <= '0;
      status_q  <= pts_pkg::StatusOk;
      fire_q    <= '0;
      k_q       <= '0;
      idx_q     <= '0;
      best_q    <= '0;
      chosen_q  <= '0;
      per_q     <= '0;
      rem_q     <= '0;
      bit_q     <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          status_q <= pts_pkg::StatusOk;
          fire_q   <= '0;
          idx_q    <= '0;
          k_q      <= (SlotW+1)'(1);
          best_q   <= 9'd256;
          chosen_q <= cur_q;
          per_q    <= '0;
          rem_q    <= '0;
          bit_q    <= '0;
          if (cmd_valid_i) begin
            if (cmd_i.action == pts_pkg::ActAdd && count_q >= CntW'(ThreadSlots)) begin
              status_q <= pts_pkg::StatusLimit;
            end
            if (cmd_i.action == pts_pkg::ActSleep && alive_q[cur_q]) begin
              asleep_q[cur_q] <= 1'b1;
            end
            if (cmd_i.action == pts_pkg::ActBlock &&
                {3'b000, cmd_i.slot} < 6'(ThreadSlots)) begin
              blocked_q[SlotW'(cmd_i.slot)] <= cmd_i.block_value;
            end
          end
        end
        StTick: time_q <= time_q + 32'd1;
        StMod: begin
          if (per_q < n_lim) begin
            if (bit_q == 6'd32) begin
              if (periods_i[per_q[1:0]] != 16'd0 && rem_q == 32'(per_q)) begin
                fire_q[per_q[1:0]] <= 1'b1;
              end
              per_q <= per_q + 3'd1;
              bit_q <= '0;
              rem_q <= '0;
            end else begin
              rem_q <= (rem_sh >= {17'd0, periods_i[per_q[1:0]]}) ?
                       32'(rem_sh - {17'd0, periods_i[per_q[1:0]]}) : rem_sh[31:0];
              bit_q <= bit_q + 6'd1;
            end
          end
        end
        StWake: begin
          if (alive_q[idx_q] && asleep_q[idx_q] && !wake_diff[31]) begin
            asleep_q[idx_q] <= 1'b0;
          end
          idx_q <= idx_q + 1'b1;
        end
        StAdd: begin
          if (status_q == pts_pkg::StatusOk && !alive_q[idx_q]) begin
            alive_q[idx_q]   <= 1'b1;
            asleep_q[idx_q]  <= 1'b0;
            blocked_q[idx_q] <= 1'b0;
            idc_q   <= idc_q + 16'd1;
            count_q <= count_q + 1'b1;
          end else if (idx_q == SlotW'(ThreadSlots - 1)) begin
            status_q <= pts_pkg::StatusLimit;
          end
          idx_q <= idx_q + 1'b1;
        end
        StKill: begin
          if (count_q == CntW'(1)) begin
            status_q <= pts_pkg::StatusLast;
          end else if (alive_q[idx_q] && ident_q[idx_q] == cmd_q.thread_id) begin
            alive_q[idx_q] <= 1'b0;
            if (count_q != '0) begin
              count_q <= count_q - 1'b1;
            end
          end else if (idx_q == SlotW'(ThreadSlots - 1)) begin
            status_q <= pts_pkg::StatusNoMatch;
          end
          idx_q <= idx_q + 1'b1;
        end
        StScan: begin
          if (k_q == (SlotW+1)'(ThreadSlots)) begin
            if (alive_q[cur_q] && !asleep_q[cur_q] && !blocked_q[cur_q] &&
                {1'b0, prio_q[cur_q]} < best_q) begin
              cur_q <= cur_q;
            end else begin
              cur_q <= chosen_q;
            end
          end else begin
            if (alive_q[scan_s] && !asleep_q[scan_s] && !blocked_q[scan_s] &&
                {1'b0, prio_q[scan_s]} < best_q) begin
              best_q   <= {1'b0, prio_q[scan_s]};
              chosen_q <= scan_s;
            end
            k_q <= k_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && cmd_valid_i) begin
      cmd_q <= cmd_i;
      if (cmd_i.action == pts_pkg::ActSleep && alive_q[cur_q]) begin
        wake_q[cur_q] <= time_q + cmd_i.duration;
      end
    end
    if (state_q == StAdd && status_q == pts_pkg::StatusOk && !alive_q[idx_q]) begin
      prio_q[idx_q]  <= cmd_q.priority_req;
      wake_q[idx_q]  <= '0;
      ident_q[idx_q] <= {idc_q, 16'(idx_q)};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(alive_q)))
    else $error("thread count disagrees with alive slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (state_q == StIdle))
    else $error("result transfer did not return the engine to idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_take_o |-> (state_q == StIdle))
    else $error("command taken while busy");

endmodule
